// File: rtl/core/efso_pkg.sv
// Shared constants, types and sine table for the shake oscillator.
package efso_pkg;

    localparam int SineTableDepth = 256;
    localparam int SineIdxW       = $clog2(SineTableDepth);

    localparam logic [2:0] REG_DURATION  = 3'd0;
    localparam logic [2:0] REG_MOD_EN    = 3'd1;
    localparam logic [2:0] REG_AM_TIMING = 3'd2;
    localparam logic [2:0] REG_AM_MAG    = 3'd3;
    localparam logic [2:0] REG_FM_TIMING = 3'd4;
    localparam logic [2:0] REG_FM_MAG    = 3'd5;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_TIME,
        ST_ENV_SETUP,
        ST_ENV_DIV,
        ST_ENV_SCALE,
        ST_PHASE,
        ST_SINE,
        ST_OUT_MUL1,
        ST_OUT_MUL2,
        ST_DONE
    } state_t;

    typedef logic [SineTableDepth-1:0][17:0] sine_tab_t;

    // Sine of idx/depth turns, Q.16, from an odd polynomial.
    function automatic logic signed [17:0] sine_q16(input logic [SineIdxW-1:0] idx);
        logic signed [63:0] d;
        logic signed [63:0] w;
        logic signed [63:0] num;
        logic signed [63:0] z;
        logic signed [63:0] z2;
        logic signed [63:0] r;
        logic signed [63:0] p;
        begin
            d = 64'(SineTableDepth);
            w = 64'(idx) * 64'sd4;
            if (w < d)
                num = w;
            else if (w < 64'sd3 * d)
                num = 64'sd2 * d - w;
            else
                num = w - 64'sd4 * d;
            z  = (num * 64'sd65536) >>> SineIdxW;
            p  = z * z;
            z2 = p / 64'sd65536;
            r  = -64'sd306;
            r  = 64'sd5223 + ((r * z2) >>> 16);
            r  = -64'sd42334 + ((r * z2) >>> 16);
            r  = 64'sd102944 + ((r * z2) >>> 16);
            r  = (r * z) >>> 16;
            if (r > 64'sd65536)
                r = 64'sd65536;
            if (r < -64'sd65536)
                r = -64'sd65536;
            sine_q16 = r[17:0];
        end
    endfunction

    function automatic sine_tab_t build_sine_tab();
        sine_tab_t tab;
        begin
            for (int i = 0; i < SineTableDepth; i++)
                tab[i] = sine_q16(SineIdxW'(i));
            return tab;
        end
    endfunction

    // Evaluated once at elaboration; read as a constant table
    localparam sine_tab_t SINE_TAB = build_sine_tab();

endpackage

// File: rtl/core/enveloped_fm_shake_oscillator_top.sv
// Shake oscillator axis: register file, sequencer and shared datapath.
// Sequence: time update, then FM and AM envelopes (set-up, divide only when needed,
// scale), phase, sine lookup and two output multiplies; a disabled axis skips to done.
// One item at a time: a new input is taken only after the result is accepted. The shared
// restoring divider (one quotient bit a cycle, 12 bits per divided envelope) serves both.
// Reset: rst_n asynchronously clears state, config, elapsed time and outputs only.
module enveloped_fm_shake_oscillator_top
    import efso_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [47:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [15:0]        time_step,
    input  logic [12:0]        attenuation,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [15:0] shake_value,
    output logic signed [15:0] am_level,
    output logic signed [15:0] fm_level
);

    logic [15:0]        duration_reg;
    logic               mod_en_reg;
    logic [47:0]        am_timing_reg;
    logic signed [15:0] am_mag_reg;
    logic [47:0]        fm_timing_reg;
    logic signed [15:0] fm_mag_reg;
    logic [15:0]        elapsed_reg;

    state_t state_reg, state_next;
    logic        env_sel_reg;          // 0: FM, 1: AM
    logic [12:0] att_reg;
    logic [15:0] step_reg;
    logic [3:0]  bit_reg;
    logic [28:0] rem_reg;              // dividend/remainder working register
    logic [15:0] div_reg;
    logic [12:0] quo_reg;
    logic        inv_reg;              // release ramp: factor = 4096 - q
    logic [12:0] fac_reg;              // fixed factor when no divide
    logic        use_div_reg;
    logic signed [15:0] am_reg, fm_reg;
    logic signed [17:0] sine_reg;
    logic signed [31:0] prod_reg;
    logic signed [15:0] res_reg;

    // Envelope set-up decode
    logic [47:0] tim;
    logic signed [15:0] mag;
    logic [15:0] atk, sus, rel;
    logic [16:0] off;
    logic [17:0] dlt;
    assign tim = env_sel_reg ? am_timing_reg : fm_timing_reg;
    assign mag = env_sel_reg ? am_mag_reg : fm_mag_reg;
    assign atk = tim[15:0];
    assign sus = tim[31:16];
    assign rel = tim[47:32];
    assign off = {1'b0, atk} + {1'b0, sus};
    assign dlt = {2'b0, elapsed_reg} - {1'b0, off};

    // Shared divider step
    logic [16:0] trial;
    assign trial = {rem_reg[28], rem_reg[27:12]} - {1'b0, div_reg};

    logic [12:0] factor;
    assign factor = use_div_reg ? (inv_reg ? 13'd4096 - quo_reg : quo_reg) : fac_reg;
    logic signed [29:0] lvl_prod;
    logic signed [29:0] lvl_rnd;
    logic signed [17:0] lvl;
    logic signed [15:0] lvl_sat;
    assign lvl_prod = mag * $signed({1'b0, factor});
    assign lvl_rnd  = (lvl_prod + 30'sd2048) >>> 12;
    assign lvl      = lvl_rnd[17:0];
    assign lvl_sat  = (lvl > 18'sd32767) ? 16'sh7FFF :
                      ((lvl < -18'sd32768) ? 16'sh8000 : lvl[15:0]);

    // Phase: (dur - t) * (4096 + fm)
    logic signed [16:0] dt_s;
    logic signed [17:0] frq;
    logic signed [34:0] x;
    logic signed [34:0] xi;
    logic [SineIdxW-1:0] idx;
    assign dt_s = $signed({1'b0, duration_reg}) - $signed({1'b0, elapsed_reg});
    assign frq  = 18'sd4096 + 18'(fm_reg);
    assign x    = dt_s * frq;
    assign xi   = (x + (35'sd1 <<< (21 - SineIdxW))) >>> (22 - SineIdxW);
    assign idx  = xi[SineIdxW-1:0];

    logic signed [33:0] p1;
    logic signed [46:0] p2;
    logic signed [46:0] v;
    assign p1 = am_reg * sine_reg;
    assign p2 = prod_reg * $signed({1'b0, att_reg});
    assign v  = (p2 + (47'sd1 <<< 27)) >>> 28;

    logic [16:0] tsum;
    assign tsum = {1'b0, elapsed_reg} + {1'b0, step_reg};

    assign cfg_ready = (state_reg == ST_IDLE);
    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = (state_reg == ST_DONE);
    assign shake_value = res_reg;
    assign am_level    = am_reg;
    assign fm_level    = fm_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:      if (in_valid) state_next = ST_TIME;
            ST_TIME:      state_next = ST_ENV_SETUP;
            ST_ENV_SETUP:
                if (!mod_en_reg || duration_reg == 16'd0) state_next = ST_DONE;
                else state_next = ST_ENV_DIV;
            ST_ENV_DIV:   if (!use_div_reg || bit_reg == 4'd0) state_next = ST_ENV_SCALE;
            ST_ENV_SCALE: state_next = env_sel_reg ? ST_PHASE : ST_ENV_SETUP;
            ST_PHASE:     state_next = ST_SINE;
            ST_SINE:      state_next = ST_OUT_MUL1;
            ST_OUT_MUL1:  state_next = ST_OUT_MUL2;
            ST_OUT_MUL2:  state_next = ST_DONE;
            ST_DONE:      if (out_ready) state_next = ST_IDLE;
            default:      state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            duration_reg  <= '0;
            mod_en_reg    <= 1'b0;
            am_timing_reg <= '0;
            am_mag_reg    <= '0;
            fm_timing_reg <= '0;
            fm_mag_reg    <= '0;
            elapsed_reg   <= '0;
            env_sel_reg   <= 1'b0;
            am_reg        <= '0;
            fm_reg        <= '0;
            res_reg       <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_DURATION:  duration_reg  <= cfg_data[15:0];
                    REG_MOD_EN:    mod_en_reg    <= cfg_data[0];
                    REG_AM_TIMING: am_timing_reg <= cfg_data;
                    REG_AM_MAG:    am_mag_reg    <= cfg_data[15:0];
                    REG_FM_TIMING: fm_timing_reg <= cfg_data;
                    REG_FM_MAG:    fm_mag_reg    <= cfg_data[15:0];
                    default: ;
                endcase
            end
            case (state_reg)
                ST_TIME:
                begin
                    elapsed_reg <= tsum[16] ? 16'hFFFF : tsum[15:0];
                    env_sel_reg <= 1'b0;
                end
                ST_ENV_SETUP:
                    if (!mod_en_reg || duration_reg == 16'd0)
                    begin
                        am_reg  <= '0;
                        fm_reg  <= '0;
                        res_reg <= '0;
                    end
                ST_ENV_SCALE:
                begin
                    if (env_sel_reg)
                        am_reg <= lvl_sat;
                    else
                        fm_reg <= lvl_sat;
                    env_sel_reg <= 1'b1;
                end
                ST_OUT_MUL2:
                    if (v > 47'sd32767)
                        res_reg <= 16'sh7FFF;
                    else if (v < -47'sd32768)
                        res_reg <= 16'sh8000;
                    else
                        res_reg <= v[15:0];
                default: ;
            endcase
        end
    end

    // Datapath registers without reset
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
                if (in_valid)
                begin
                    step_reg <= time_step;
                    att_reg  <= attenuation;
                end
            ST_ENV_SETUP:
            begin
                bit_reg     <= 4'd12;
                quo_reg     <= '0;
                use_div_reg <= 1'b0;
                inv_reg     <= 1'b0;
                fac_reg     <= 13'd4096;
                if (rel != 16'd0 && !dlt[17])
                begin
                    if (dlt[15:0] >= rel)
                        fac_reg <= 13'd0;
                    else
                    begin
                        use_div_reg <= 1'b1;
                        inv_reg     <= 1'b1;
                        div_reg     <= rel;
                        rem_reg     <= {dlt[15:0], 13'd0};
                    end
                end
                else if (atk != 16'd0 && elapsed_reg < atk)
                begin
                    use_div_reg <= 1'b1;
                    div_reg     <= atk;
                    rem_reg     <= {elapsed_reg, 13'd0};
                end
            end
            ST_ENV_DIV:
                if (use_div_reg && bit_reg != 4'd0)
                begin
                    // restoring step on (rem << 1), quotient of n*4096/div
                    bit_reg <= bit_reg - 4'd1;
                    if (!trial[16] || rem_reg[28])
                    begin
                        rem_reg <= {trial[15:0], rem_reg[11:0], 1'b0};
                        quo_reg <= {quo_reg[11:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg <= {rem_reg[27:0], 1'b0};
                        quo_reg <= {quo_reg[11:0], 1'b0};
                    end
                end
            ST_PHASE:    sine_reg <= $signed(SINE_TAB[idx]);
            ST_SINE:     prod_reg <= p1[31:0];
            default: ;
        endcase
    end

endmodule

module enveloped_fm_shake_oscillator_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               cfg_valid,
    input logic               cfg_ready,
    input logic               in_valid,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input logic signed [15:0] shake_value,
    input logic signed [15:0] am_level,
    input logic signed [15:0] fm_level
);

    // hold the result while the receiver stalls
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(shake_value)
            && $stable(am_level) && $stable(fm_level));

    assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid));

    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready);

    assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready == in_ready);

endmodule

bind enveloped_fm_shake_oscillator_top enveloped_fm_shake_oscillator_checker u_checker (.*);

// File: verif/tb.sv
// Self-checking testbench for the shake oscillator axis.
module tb
    import efso_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [2:0] REG_UNMAPPED = 3'd6;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int SETTLE_CYCLES = 40;
    localparam int CONFIG_BLOCKS = 12;
    localparam int ITEMS_PER_BLOCK = 155;

    typedef struct packed {
        logic signed [15:0] shake;
        logic signed [15:0] am;
        logic signed [15:0] fm;
    } axis_result_t;

    typedef struct {
        logic [15:0]  dt;
        logic [12:0]  att;
        bit           known;
        axis_result_t res;
    } tick_row_t;

    logic               clk;
    logic               rst_n;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [2:0]         cfg_index;
    logic [47:0]        cfg_data;
    logic               in_valid;
    logic               in_ready;
    logic [15:0]        time_step;
    logic [12:0]        attenuation;
    logic               out_valid;
    logic               out_ready;
    logic signed [15:0] shake_value;
    logic signed [15:0] am_level;
    logic signed [15:0] fm_level;

    enveloped_fm_shake_oscillator_top uut (.*);

    // shadow of the block's registers and elapsed time
    logic [15:0]        m_duration;
    logic               m_enable;
    logic [47:0]        m_am_timing;
    logic signed [15:0] m_am_mag;
    logic [47:0]        m_fm_timing;
    logic signed [15:0] m_fm_mag;
    logic [15:0]        m_elapsed;

    axis_result_t expected_shakes[$];
    tick_row_t    directed_ticks[$];
    int           fail_count;
    int           idle_cycles;
    int           send_idle_pct;
    int           recv_idle_pct;

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    function automatic longint floor_div(longint a, longint b);
        longint q;
        begin
            q = a / b;
            if ((a % b) != 0 && ((a < 0) != (b < 0)))
                q = q - 1;
            return q;
        end
    endfunction

    function automatic longint clamp_range(longint v, longint lo, longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function automatic longint envelope_level(logic [47:0] timing, logic signed [15:0] mag,
                                              longint t);
        longint atk, sus, rel, off, f, d;
        begin
            atk = timing[15:0];
            sus = timing[31:16];
            rel = timing[47:32];
            off = atk + sus;
            f = 4096;
            if (atk > 0 && t < atk)
                f = (t * 4096) / atk;
            if (rel > 0 && t >= off)
            begin
                d = t - off;
                f = (d >= rel) ? 0 : 4096 - (d * 4096) / rel;
            end
            return clamp_range(floor_div(longint'(mag) * f + 2048, 4096), -32768, 32767);
        end
    endfunction

    function automatic longint sine_turns(longint idx);
        longint w, num, z, z2, r;
        begin
            w = 4 * idx;
            if (w < SineTableDepth)
                num = w;
            else if (w < 3 * SineTableDepth)
                num = 2 * SineTableDepth - w;
            else
                num = w - 4 * SineTableDepth;
            z = floor_div(num * 65536, SineTableDepth);
            z2 = (z * z) / 65536;
            r = -306;
            r = 5223 + floor_div(r * z2, 65536);
            r = -42334 + floor_div(r * z2, 65536);
            r = 102944 + floor_div(r * z2, 65536);
            return clamp_range(floor_div(r * z, 65536), -65536, 65536);
        end
    endfunction

    // advance the shadow time and work out the result of one tick
    function automatic axis_result_t predict_shake(logic [15:0] dt, logic [12:0] att);
        axis_result_t r;
        longint t, am, fm, x, idx, v;
        begin
            t = longint'(m_elapsed) + longint'(dt);
            if (t > 65535)
                t = 65535;
            m_elapsed = t[15:0];
            r = '0;
            if (m_enable && m_duration != 0)
            begin
                fm = envelope_level(m_fm_timing, m_fm_mag, t);
                am = envelope_level(m_am_timing, m_am_mag, t);
                x = (longint'(m_duration) - t) * (4096 + fm);
                idx = floor_div(x * SineTableDepth + (longint'(1) << 21), longint'(1) << 22);
                idx = idx % SineTableDepth;
                if (idx < 0)
                    idx = idx + SineTableDepth;
                v = floor_div(am * sine_turns(idx) * longint'(att) + (longint'(1) << 27),
                              longint'(1) << 28);
                v = clamp_range(v, -32768, 32767);
                r.shake = v[15:0];
                r.am = am[15:0];
                r.fm = fm[15:0];
            end
            return r;
        end
    endfunction

    always @(posedge clk)
    begin
        axis_result_t exp_r;
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("[enveloped_fm_shake_oscillator_top] ERROR");
                $finish;
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_DURATION:  m_duration = cfg_data[15:0];
                    REG_MOD_EN:    m_enable = cfg_data[0];
                    REG_AM_TIMING: m_am_timing = cfg_data;
                    REG_AM_MAG:    m_am_mag = cfg_data[15:0];
                    REG_FM_TIMING: m_fm_timing = cfg_data;
                    REG_FM_MAG:    m_fm_mag = cfg_data[15:0];
                    default:       ;
                endcase
            end
            if (in_valid && in_ready)
                expected_shakes.push_back(predict_shake(time_step, attenuation));
            if (out_valid && out_ready)
            begin
                if (expected_shakes.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected result: shake %0d am %0d fm %0d",
                                 shake_value, am_level, fm_level);
                end
                else
                begin
                    exp_r = expected_shakes.pop_front();
                    if (shake_value !== exp_r.shake || am_level !== exp_r.am
                        || fm_level !== exp_r.fm)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("mismatch: shake %0d/%0d am %0d/%0d fm %0d/%0d (exp/got)",
                                     exp_r.shake, shake_value, exp_r.am, am_level,
                                     exp_r.fm, fm_level);
                    end
                end
            end
        end
    end

    // directed rows with a typed-in result are checked here as well
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready && directed_ticks.size() > 0)
        begin
            if (directed_ticks[0].known && {shake_value, am_level, fm_level}
                !== directed_ticks[0].res)
            begin
                fail_count++;
                if (fail_count <= 10)
                    $display("directed mismatch: exp %h got %h", directed_ticks[0].res,
                             {shake_value, am_level, fm_level});
            end
            void'(directed_ticks.pop_front());
        end
    end

    always @(negedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // caller stands at a falling edge; returns at the falling edge after acceptance
    task automatic write_reg(logic [2:0] idx, logic [47:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
    endtask

    task automatic send_tick(logic [15:0] dt, logic [12:0] att);
        int gap;
        begin
            gap = ($urandom_range(99) < send_idle_pct) ? $urandom_range(4, 1) : 0;
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            in_valid <= 1'b1;
            time_step <= dt;
            attenuation <= att;
            do
                @(posedge clk);
            while (!in_ready);
            @(negedge clk);
        end
    endtask

    task automatic drain;
        in_valid <= 1'b0;
        while (expected_shakes.size() > 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    function automatic logic [15:0] pick_span();
        case ($urandom_range(5))
            0:       return 16'd0;
            1:       return 16'hFFFF;
            2:       return 16'($urandom_range(64, 1));
            3:       return 16'($urandom_range(4000, 1));
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] pick_magnitude();
        case ($urandom_range(4))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return 16'($urandom_range(4096)) ^ {16{$urandom_range(1) == 1}};
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic randomise_config(bit full_range);
        write_reg(REG_DURATION, ($urandom_range(9) == 0) ? 48'd0 :
                  (full_range ? 48'hFFFF : 48'($urandom)));
        write_reg(REG_MOD_EN, 48'($urandom_range(9) != 0));
        write_reg(REG_AM_TIMING, {pick_span(), pick_span(), pick_span()});
        write_reg(REG_AM_MAG, {32'($urandom), pick_magnitude()});
        write_reg(REG_FM_TIMING, {pick_span(), pick_span(), pick_span()});
        write_reg(REG_FM_MAG, {32'($urandom), pick_magnitude()});
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        tick_row_t row;
        logic [15:0] dt;
        logic [12:0] att;
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = REG_DURATION;
        cfg_data = '0;
        in_valid = 1'b0;
        time_step = '0;
        attenuation = '0;
        out_ready = 1'b0;
        m_duration = '0;
        m_enable = 1'b0;
        m_am_timing = '0;
        m_am_mag = '0;
        m_fm_timing = '0;
        m_fm_mag = '0;
        m_elapsed = '0;
        fail_count = 0;
        idle_cycles = 0;
        send_idle_pct = 38;
        recv_idle_pct = 62;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // after reset every output is forced to zero
        directed_ticks.push_back('{16'd0, 13'd4096, 1'b1, '0});
        directed_ticks.push_back('{16'd5, 13'd8191, 1'b1, '0});
        directed_ticks.push_back('{16'd0, 13'd0, 1'b1, '0});
        foreach (directed_ticks[i])
            send_tick(directed_ticks[i].dt, directed_ticks[i].att);
        drain();

        // enabled but zero duration: still silent; unmapped index is ignored
        write_reg(REG_MOD_EN, 48'd1);
        write_reg(REG_UNMAPPED, 48'hFFFF_FFFF_FFFF);
        cfg_valid <= 1'b0;
        directed_ticks.push_back('{16'd3, 13'd4096, 1'b1, '0});
        send_tick(16'd3, 13'd4096);
        drain();

        // attack, sustain and release around the early ticks; peak magnitudes
        write_reg(REG_DURATION, 48'd1000);
        write_reg(REG_AM_TIMING, {16'd40, 16'd20, 16'd30});
        write_reg(REG_AM_MAG, 48'h7FFF);
        write_reg(REG_FM_TIMING, {16'd0, 16'd10, 16'd0});
        write_reg(REG_FM_MAG, 48'h8000);
        cfg_valid <= 1'b0;
        for (int i = 0; i < 20; i++)
        begin
            row.dt = (i == 0) ? 16'd0 : 16'(i % 7 + 1);
            row.att = (i % 3 == 0) ? 13'd8191 : ((i % 3 == 1) ? 13'd4096 : 13'd0);
            row.known = 1'b0;
            row.res = '0;
            directed_ticks.push_back(row);
            send_tick(row.dt, row.att);
        end
        drain();

        for (int blk = 0; blk < CONFIG_BLOCKS; blk++)
        begin
            send_idle_pct = (blk < 4) ? 38 : ((blk < 8) ? 62 : 0);
            recv_idle_pct = (blk < 4) ? 62 : ((blk < 8) ? 38 : 0);
            randomise_config(blk == CONFIG_BLOCKS - 1);
            for (int i = 0; i < ITEMS_PER_BLOCK; i++)
            begin
                // keep time short of saturation until the last block
                if (blk == CONFIG_BLOCKS - 1 && i > 20)
                    dt = 16'($urandom);
                else
                    dt = 16'($urandom_range(40));
                att = ($urandom_range(3) == 0) ? 13'($urandom) : 13'($urandom_range(4096));
                send_tick(dt, att);
            end
            drain();
        end

        repeat (SETTLE_CYCLES) @(negedge clk);
        if (fail_count == 0)
            $display("[enveloped_fm_shake_oscillator_top] OK");
        else
            $display("[enveloped_fm_shake_oscillator_top] ERROR");
        $finish;
    end

endmodule
